/* design/mmp_pkg.sv */
// shared types, constants and helpers for the modular 2x2 matrix power unit
package mmp_pkg;

    localparam int unsigned MATRIX_DIM = 2;
    localparam int unsigned ENTRIES    = MATRIX_DIM * MATRIX_DIM;
    localparam int unsigned ENTRY_W    = 30;
    localparam int unsigned POWER_W    = 63;
    localparam int unsigned IDX_W      = $clog2(ENTRIES);
    localparam int unsigned TAG_W      = IDX_W + 1;
    localparam int unsigned IN_DATA_W  = 184;
    localparam int unsigned OUT_DATA_W = 120;

    localparam logic [ENTRY_W-1:0] PRIME_MOD = 30'd998244353;

    // barrett constant floor(2^60 / p), fits in 31 bits
    localparam logic [63:0] MU_FULL    = 64'h1000_0000_0000_0000 / 64'd998244353;
    localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

    typedef logic [ENTRY_W-1:0] t_entry;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        t_entry           a;
        t_entry           b;
    } t_mm_req;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        t_entry           res;
    } t_mm_rsp;

    // one conditional subtract, input below twice the modulus
    function automatic t_entry mod_fold(input logic [ENTRY_W:0] x);
        logic [ENTRY_W:0] d;
        d = x - {1'b0, PRIME_MOD};
        if (x >= {1'b0, PRIME_MOD}) begin
            return d[ENTRY_W-1:0];
        end else begin
            return x[ENTRY_W-1:0];
        end
    endfunction

endpackage

/* design/mmp_modmul.sv */
// pipelined modular multiplier, barrett reduction over five register stages
module mmp_modmul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mmp_pkg::t_mm_req i_req,
    output mmp_pkg::t_mm_rsp o_rsp
);

    logic [mmp_pkg::TAG_W-1:0] r_tag1, r_tag2, r_tag3, r_tag4, r_tag5;
    logic                      r_v1, r_v2, r_v3, r_v4, r_v5;

    logic [59:0]          r_p1;
    logic [61:0]          r_q2;
    logic [31:0]          r_x2;
    logic [31:0]          r_qp3;
    logic [31:0]          r_x3;
    logic [30:0]          r_r4;
    mmp_pkg::t_entry      r_res5;

    logic [60:0]          w_qp;
    logic [31:0]          w_r4;
    logic [31:0]          w_r4_sub;

    assign w_qp     = 61'(r_q2[61:31]) * 61'(mmp_pkg::PRIME_MOD);
    assign w_r4     = r_x3 - r_qp3;
    assign w_r4_sub = w_r4 - 32'(mmp_pkg::PRIME_MOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
        r_tag1 <= i_req.tag;
        r_tag2 <= r_tag1;
        r_tag3 <= r_tag2;
        r_tag4 <= r_tag3;
        r_tag5 <= r_tag4;
        // full product, below p^2
        r_p1 <= 60'(i_req.a) * 60'(i_req.b);
        // quotient estimate
        r_q2 <= 62'(r_p1[59:29]) * 62'(mmp_pkg::BARRETT_MU);
        r_x2 <= r_p1[31:0];
        // remainder is below 3p, so the low 32 bits are enough
        r_qp3 <= w_qp[31:0];
        r_x3  <= r_x2;
        if (w_r4 >= 32'(mmp_pkg::PRIME_MOD)) begin
            r_r4 <= w_r4_sub[30:0];
        end else begin
            r_r4 <= w_r4[30:0];
        end
        r_res5 <= mmp_pkg::mod_fold(r_r4);
    end

    assign o_rsp.valid = r_v5;
    assign o_rsp.tag   = r_tag5;
    assign o_rsp.res   = r_res5;

endmodule

/* design/mod_matrix2x2_power_unit.sv */
// 2x2 matrix power modulo 998244353: sequencer around one shared modular multiplier
// work per item: none for a zero exponent, otherwise one multiply per set exponent bit
//   and one square per bit below the top set bit
// worst case, all 63 exponent bits set: 63 multiplies and 62 squares
// throughput: one item at a time, ready only while idle; a finished result waits in the
//   output register while the next item is taken, a held output stalls the done state
// reset: synchronous active low, returns to idle with no result pending
module mod_matrix2x2_power_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // base_00, base_01, base_10, base_11, power, one pad bit
    input  logic [183:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // res_00, res_01, res_10, res_11
    output logic [119:0] o_m_tdata
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_ISSUE = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_WB    = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    mmp_pkg::t_entry r_base [mmp_pkg::ENTRIES];
    mmp_pkg::t_entry r_acc  [mmp_pkg::ENTRIES];
    mmp_pkg::t_entry r_prod [mmp_pkg::ENTRIES];
    mmp_pkg::t_entry r_out  [mmp_pkg::ENTRIES];
    mmp_pkg::t_entry r_part;

    logic [mmp_pkg::POWER_W-1:0] r_pow;
    logic                        r_sqr;
    logic [mmp_pkg::TAG_W-1:0]   r_issue;
    logic                        r_out_valid;

    mmp_pkg::t_mm_req r_req;
    mmp_pkg::t_mm_rsp w_rsp;

    logic [mmp_pkg::IDX_W-1:0] w_ia, w_ib;
    mmp_pkg::t_entry           w_op_a, w_op_b;
    logic                      w_accept, w_out_free, w_last_rsp;

    mmp_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    // issue index bits: row, column, inner term
    assign w_ia   = {r_issue[2], r_issue[0]};
    assign w_ib   = {r_issue[0], r_issue[1]};
    assign w_op_a = r_sqr ? r_base[w_ia] : r_acc[w_ia];
    assign w_op_b = r_base[w_ib];

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_last_rsp = w_rsp.valid && (w_rsp.tag == mmp_pkg::TAG_W'(2 * mmp_pkg::ENTRIES - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_pow == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (r_issue == mmp_pkg::TAG_W'(2 * mmp_pkg::ENTRIES - 1)) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_last_rsp) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (r_sqr) begin
                    n_state = ST_CHECK;
                end else if (r_pow[mmp_pkg::POWER_W-1:1] == '0) begin
                    // no squaring needed after the top bit
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_req.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req.valid <= (r_state == ST_ISSUE);
            r_req.tag   <= r_issue;
            r_req.a     <= w_op_a;
            r_req.b     <= w_op_b;

            if (w_accept) begin
                for (int e = 0; e < mmp_pkg::ENTRIES; e++) begin
                    r_base[e] <= mmp_pkg::mod_fold(
                        {1'b0, i_s_tdata[e*mmp_pkg::ENTRY_W +: mmp_pkg::ENTRY_W]});
                end
                r_acc[0] <= mmp_pkg::t_entry'(1);
                r_acc[1] <= '0;
                r_acc[2] <= '0;
                r_acc[3] <= mmp_pkg::t_entry'(1);
                r_pow    <= i_s_tdata[mmp_pkg::ENTRIES*mmp_pkg::ENTRY_W +: mmp_pkg::POWER_W];
            end

            case (r_state)
                ST_CHECK: begin
                    r_sqr   <= !r_pow[0];
                    r_issue <= '0;
                end
                ST_ISSUE: begin
                    r_issue <= r_issue + 1'b1;
                end
                ST_WB: begin
                    if (r_sqr) begin
                        r_base <= r_prod;
                        r_pow  <= r_pow >> 1;
                    end else begin
                        r_acc   <= r_prod;
                        r_sqr   <= 1'b1;
                        r_issue <= '0;
                    end
                end
                default: begin
                end
            endcase

            // pair up the two inner terms of each entry
            if (w_rsp.valid) begin
                if (!w_rsp.tag[0]) begin
                    r_part <= w_rsp.res;
                end else begin
                    r_prod[w_rsp.tag[mmp_pkg::TAG_W-1:1]] <=
                        mmp_pkg::mod_fold({1'b0, r_part} + {1'b0, w_rsp.res});
                end
            end

            if ((r_state == ST_DONE) && w_out_free) begin
                r_out       <= r_acc;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out[3], r_out[2], r_out[1], r_out[0]};

endmodule
